// File: rtl/core/nds_pkg.sv
`timescale 1ns / 1ps

package nds_pkg;

    localparam int TUBES      = 4;
    localparam int CODES      = 11;
    localparam int PAT_W      = 64;
    localparam int NIB_W      = 4;
    localparam int BEATS      = PAT_W / NIB_W;
    localparam int BEAT_W     = $clog2(BEATS + 1);
    localparam int PIN_W      = 7;

    localparam logic [BEAT_W-1:0] LATCH_BEAT = BEAT_W'(BEATS);
    localparam logic [BEAT_W-1:0] LAST_SHIFT = BEAT_W'(BEATS - 1);

    // pin numbers 1..64, one row per tube; codes 0-9 numerals, code 10 the dot
    localparam logic [PIN_W-1:0] PIN_TABLE [TUBES][CODES] = '{
        '{7'd18, 7'd20, 7'd21, 7'd22, 7'd43, 7'd44, 7'd45, 7'd46, 7'd47, 7'd48, 7'd19},
        '{7'd13, 7'd15, 7'd16, 7'd17, 7'd49, 7'd50, 7'd51, 7'd52, 7'd53, 7'd12, 7'd14},
        '{7'd7,  7'd9,  7'd10, 7'd11, 7'd54, 7'd55, 7'd56, 7'd57, 7'd58, 7'd59, 7'd8},
        '{7'd2,  7'd4,  7'd5,  7'd6,  7'd60, 7'd61, 7'd62, 7'd63, 7'd64, 7'd1,  7'd3}
    };

    typedef logic [3:0]             t_code;
    typedef t_code [TUBES-1:0]      t_digits;
    typedef logic [PAT_W-1:0]       t_pattern;

    typedef struct packed {
        logic busy;
        logic done;
    } t_ser_status;

endpackage

// File: rtl/core/nds_if.sv
`timescale 1ns / 1ps

interface nds_in_if;
    logic       valid;
    logic       ready;
    logic [3:0] digit_0;
    logic [3:0] digit_1;
    logic [3:0] digit_2;
    logic [3:0] digit_3;

    modport source (output valid, digit_0, digit_1, digit_2, digit_3, input ready);
    modport sink   (input valid, digit_0, digit_1, digit_2, digit_3, output ready);
endinterface

interface nds_out_if;
    logic       valid;
    logic       ready;
    logic [3:0] data_nibble;
    logic       shift_strobe;
    logic       latch_strobe;
    logic       last;

    modport source (output valid, data_nibble, shift_strobe, latch_strobe, last,
                    input ready);
    modport sink   (input valid, data_nibble, shift_strobe, latch_strobe, last,
                    output ready);
endinterface

// File: rtl/core/nds_pattern.sv
`timescale 1ns / 1ps

module nds_pattern
    import nds_pkg::*;
(
    input  t_digits  i_digits,
    output t_pattern o_pattern
);

    t_pattern clear_mask;
    logic [PIN_W-1:0] pin;

    always_comb begin
        clear_mask = '0;
        pin        = '0;
        for (int t = 0; t < TUBES; t++) begin
            if (i_digits[t] < 4'(CODES)) begin
                pin = PIN_TABLE[t][i_digits[t]] - 7'd1;
                clear_mask[pin[5:0]] = 1'b1;
            end
        end
        o_pattern = ~clear_mask;
    end

endmodule

// File: rtl/core/nds_shifter.sv
`timescale 1ns / 1ps

module nds_shifter
    import nds_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_load,
    input  t_pattern      i_pattern,
    output t_ser_status   o_status,
    nds_out_if.source     o_out
);

    logic              r_valid, n_valid;
    logic [BEAT_W-1:0] r_beat, n_beat;
    t_pattern          r_pat, n_pat;
    logic              fire;
    logic              is_latch;

    assign is_latch = (r_beat == LATCH_BEAT);
    assign fire     = r_valid && o_out.ready;

    assign o_out.valid        = r_valid;
    assign o_out.data_nibble  = r_pat[PAT_W-1 -: NIB_W];
    assign o_out.shift_strobe = !is_latch;
    assign o_out.latch_strobe = is_latch;
    assign o_out.last         = is_latch;

    assign o_status.busy = r_valid;
    assign o_status.done = fire && is_latch;

    always_comb begin
        n_valid = r_valid;
        n_beat  = r_beat;
        n_pat   = r_pat;
        if (i_load) begin
            n_valid = 1'b1;
            n_beat  = '0;
            n_pat   = i_pattern;
        end else if (fire) begin
            if (is_latch) begin
                n_valid = 1'b0;
            end else begin
                n_beat = r_beat + 1'b1;
                // final shift nibble stays on the lines through the latch beat
                if (r_beat != LAST_SHIFT) begin
                    n_pat = {r_pat[PAT_W-NIB_W-1:0], {NIB_W{1'b0}}};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_beat  <= '0;
        end else begin
            r_valid <= n_valid;
            r_beat  <= n_beat;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pat <= n_pat;
    end

endmodule

// File: rtl/core/nixie_digit_serializer.sv
`timescale 1ns / 1ps

// Four-tube display serializer. One input transaction carries four tube codes
// (0-9 numeral, 10 dot, 11-15 blank) and produces 17 output transactions: 16
// shift beats carrying the active-low 64-bit pin pattern a nibble at a time,
// bits 63..60 first, then one latch beat (last = 1) that repeats the final
// nibble. A one-deep input register takes the next update while the current
// one is still shifting out, so updates follow each other with no idle beat
// between them.
module nixie_digit_serializer
    import nds_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    nds_in_if.sink      i_in,
    nds_out_if.source   o_out
);

    logic        r_a_valid;
    t_digits     r_a_digits;
    logic        a_take;
    t_pattern    pattern;
    t_ser_status ser_status;

    assign a_take     = r_a_valid && (!ser_status.busy || ser_status.done);
    assign i_in.ready = !r_a_valid || a_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_a_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_a_digits <= {i_in.digit_3, i_in.digit_2, i_in.digit_1, i_in.digit_0};
        end
    end

    nds_pattern u_pattern (
        .i_digits  (r_a_digits),
        .o_pattern (pattern)
    );

    nds_shifter u_shifter (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (a_take),
        .i_pattern (pattern),
        .o_status  (ser_status),
        .o_out     (o_out)
    );

    a_start_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        a_take |=> (o_out.valid && o_out.shift_strobe))
        else $error("update did not start with a shift beat");

    a_no_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready && !o_out.last) |=> o_out.valid)
        else $error("output dropped inside an update");

    a_in_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> r_a_valid)
        else $error("accepted transaction not held");

    a_load_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ser_status.busy && !ser_status.done) |-> !a_take)
        else $error("pattern loaded while serializer busy");

endmodule

// File: dv/nds_beat_checker.sv
`timescale 1ns / 1ps

module nds_beat_checker
    import nds_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    nds_in_if       i_in_mon,
    nds_out_if      i_out_mon,
    output int      o_fail_count,
    output int      o_outstanding
);

    localparam int unsigned TUBE_PINS [TUBES][CODES] = '{
        '{18, 20, 21, 22, 43, 44, 45, 46, 47, 48, 19},
        '{13, 15, 16, 17, 49, 50, 51, 52, 53, 12, 14},
        '{ 7,  9, 10, 11, 54, 55, 56, 57, 58, 59,  8},
        '{ 2,  4,  5,  6, 60, 61, 62, 63, 64,  1,  3}
    };

    typedef struct packed {
        logic [NIB_W-1:0] nibble;
        logic             shift;
        logic             latch;
        logic             last_beat;
    } t_beat;

    t_beat pending_beats [$];
    int    mismatches;

    assign o_fail_count = mismatches;

    // active-low pin pattern; blank codes clear nothing
    function automatic t_pattern tube_pattern(input t_digits codes);
        t_pattern pat;
        pat = '1;
        for (int t = 0; t < TUBES; t++) begin
            if (int'(codes[t]) < CODES) begin
                pat[TUBE_PINS[t][codes[t]] - 1] = 1'b0;
            end
        end
        return pat;
    endfunction

    task automatic queue_update_beats(input t_digits codes);
        t_pattern pat;
        t_beat    beat;
        pat = tube_pattern(codes);
        for (int k = 0; k < BEATS; k++) begin
            beat = '{nibble: pat[PAT_W-1-NIB_W*k -: NIB_W], shift: 1'b1,
                     latch: 1'b0, last_beat: 1'b0};
            pending_beats.push_back(beat);
        end
        beat = '{nibble: pat[NIB_W-1:0], shift: 1'b0, latch: 1'b1, last_beat: 1'b1};
        pending_beats.push_back(beat);
    endtask

    task automatic check_field(input string what, input logic [3:0] want,
                               input logic [3:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, what, want, got);
            mismatches++;
        end
    endtask

    initial begin
        mismatches    = 0;
        o_outstanding = 0;
    end

    always @(posedge i_clk) begin
        t_beat   want;
        t_digits codes;
        if (!i_rst_n) begin
            pending_beats.delete();
        end else begin
            if (i_in_mon.valid && i_in_mon.ready) begin
                codes = {i_in_mon.digit_3, i_in_mon.digit_2,
                         i_in_mon.digit_1, i_in_mon.digit_0};
                queue_update_beats(codes);
            end
            if (i_out_mon.valid && i_out_mon.ready) begin
                if (pending_beats.size() == 0) begin
                    $display("%0t: unexpected output transaction, expected none actual nibble %h",
                             $time, i_out_mon.data_nibble);
                    mismatches++;
                end else begin
                    want = pending_beats.pop_front();
                    check_field("data_nibble", want.nibble, i_out_mon.data_nibble);
                    check_field("shift_strobe", {3'b000, want.shift},
                                {3'b000, i_out_mon.shift_strobe});
                    check_field("latch_strobe", {3'b000, want.latch},
                                {3'b000, i_out_mon.latch_strobe});
                    check_field("last", {3'b000, want.last_beat},
                                {3'b000, i_out_mon.last});
                end
            end
        end
        o_outstanding <= pending_beats.size();
    end

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps

module tb;
    import nds_pkg::*;

    localparam int    UPDATE_COUNT = 310;
    localparam int    MAX_GAP      = 18;
    localparam int    DRAIN_CYCLES = 40;
    localparam t_code DOT_CODE     = 4'd10;
    localparam t_code BLANK_LO     = 4'd11;
    localparam t_code BLANK_HI     = 4'd15;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   outstanding;
    int   stall_left;
    bit   out_no_stall;

    nds_in_if  in_ch ();
    nds_out_if out_ch ();

    nixie_digit_serializer i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    nds_beat_checker i_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_mon      (in_ch),
        .i_out_mon     (out_ch),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    initial begin
        #5_000_000;
        $display("nixie_digit_serializer verification failed");
        $finish;
    end

    // sink side: random stall before each output transaction, with stall-free stretches
    initial begin
        out_ch.ready = 1'b0;
        stall_left   = 0;
        out_no_stall = 1'b0;
    end

    always @(posedge i_clk) begin
        int draw;
        draw = $urandom_range(0, MAX_GAP);
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            stall_left   <= draw;
        end else if (out_ch.valid && out_ch.ready) begin
            if ($urandom_range(0, 39) == 0) begin
                out_no_stall <= !out_no_stall;
            end
            if (out_no_stall || draw == 0) begin
                stall_left <= 0;
            end else begin
                stall_left   <= draw - 1;
                out_ch.ready <= 1'b0;
            end
        end else if (!out_ch.ready) begin
            if (stall_left == 0) begin
                out_ch.ready <= 1'b1;
            end else begin
                stall_left <= stall_left - 1;
            end
        end
    end

    task automatic send_update(input t_digits codes, input int gap);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.digit_0 <= codes[0];
        in_ch.digit_1 <= codes[1];
        in_ch.digit_2 <= codes[2];
        in_ch.digit_3 <= codes[3];
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    function automatic t_code random_code();
        if ($urandom_range(0, 9) < 8) begin
            return t_code'($urandom_range(0, DOT_CODE));
        end
        return t_code'($urandom_range(BLANK_LO, BLANK_HI));
    endfunction

    initial begin
        t_digits codes;
        int      gap;
        bit      in_no_gap;
        i_rst_n       = 1'b0;
        in_ch.valid   = 1'b0;
        in_ch.digit_0 = '0;
        in_ch.digit_1 = '0;
        in_ch.digit_2 = '0;
        in_ch.digit_3 = '0;
        in_no_gap     = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // every code on every tube, numerals through dot and all blanks
        for (int k = 0; k <= BLANK_HI; k++) begin
            codes = {t_code'(k), t_code'(k), t_code'(k), t_code'(k)};
            send_update(codes, $urandom_range(0, MAX_GAP));
        end
        send_update({DOT_CODE, 4'd9, BLANK_HI, 4'd0}, 0);
        send_update({BLANK_LO, DOT_CODE, 4'd9, 4'd0}, 0);
        send_update({4'd0, 4'd9, DOT_CODE, BLANK_LO}, $urandom_range(0, MAX_GAP));
        send_update({4'd7, BLANK_HI, DOT_CODE, 4'd3}, 0);

        for (int n = 20; n < UPDATE_COUNT; n++) begin
            if ($urandom_range(0, 19) == 0) begin
                in_no_gap = !in_no_gap;
            end
            for (int t = 0; t < TUBES; t++) begin
                codes[t] = random_code();
            end
            gap = in_no_gap ? 0 : $urandom_range(0, MAX_GAP);
            send_update(codes, gap);
        end
        in_ch.valid <= 1'b0;

        do @(posedge i_clk); while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("nixie_digit_serializer verification clean");
        end else begin
            $display("nixie_digit_serializer verification failed");
        end
        $finish;
    end

endmodule
